@@ src/tfsdp_pkg.sv @@
// ---------------------------------------------------------------------------
// Tagged frame store package
// Shared sizes, opcodes, status codes and the item records passed between
// the front end, the execution back end and the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

package tfsdp_pkg;

  localparam int NUM_TAGS        = 32;
  localparam int FRAMES_PER_PAGE = 8;
  localparam int NUM_PAGES       = (NUM_TAGS + FRAMES_PER_PAGE - 1) / FRAMES_PER_PAGE;

  localparam int SLOT_W  = $clog2(NUM_TAGS);
  localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int FRAME_W = (FRAMES_PER_PAGE > 1) ? $clog2(FRAMES_PER_PAGE) : 1;

  localparam int TAG_W   = 6;
  localparam int VALUE_W = 48;
  localparam int WORD_W  = 64;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_MISMATCH   = 2'd2;
  localparam logic [1:0] ST_NONE_DIRTY = 2'd3;

  localparam logic [7:0] TAG_BYTE_BLANK = 8'h00;
  localparam logic [7:0] TAG_BYTE_ERASED = 8'hff;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // One classified command, as queued between front and back.
  typedef struct packed {
    logic [1:0]         opcode;
    logic               bad;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic [7:0]         stb;
    logic [7:0]         pad;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic               unchanged;
    logic [VALUE_W-1:0] read_value;
    logic [1:0]         page_index;
    logic [2:0]         frame_index;
    logic [WORD_W-1:0]  frame_word;
    logic               last;
  } res_t;

  function automatic logic [PAGE_W-1:0] page_of(input logic [SLOT_W-1:0] slot);
    return PAGE_W'(slot / FRAMES_PER_PAGE);
  endfunction

  function automatic logic [FRAME_W-1:0] frame_of(input logic [SLOT_W-1:0] slot);
    return FRAME_W'(slot % FRAMES_PER_PAGE);
  endfunction

endpackage

`default_nettype wire

@@ src/tfsdp_front.sv @@
// ---------------------------------------------------------------------------
// Tagged frame store front end
// Accepts items, checks the tag range, forms the frame slot and holds the
// classified commands in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tfsdp_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [1:0]               opcode,
  input  wire logic [5:0]               tag,
  input  wire logic [7:0]               stored_tag_byte,
  input  wire logic [7:0]               pad_byte,
  input  wire logic [47:0]              value,
  output logic                          cmd_valid,
  output tfsdp_pkg::cmd_t               cmd,
  input  wire logic                     cmd_take
);
  import tfsdp_pkg::*;

  cmd_t       q [2];
  cmd_t       incoming;
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push_ok;
  logic       take_ok;
  logic       in_range;

  // Tags run from 1 to NUM_TAGS; anything else is answered as empty.
  assign in_range = (tag != '0) && ({1'b0, tag} <= (TAG_W + 1)'(NUM_TAGS));

  always_comb begin
    incoming.opcode = opcode;
    incoming.bad    = !in_range;
    incoming.slot   = SLOT_W'(tag - 6'd1);
    incoming.tag    = tag;
    incoming.stb    = stored_tag_byte;
    incoming.pad    = pad_byte;
    incoming.value  = value;
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign push_ok   = push && !full;
  assign take_ok   = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push_ok) wp <= ~wp;
      if (take_ok) rp <= ~rp;
      cnt <= cnt + 2'(push_ok) - 2'(take_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q[wp] <= incoming;
  end

endmodule

`default_nettype wire

@@ src/tfsdp_back.sv @@
// ---------------------------------------------------------------------------
// Tagged frame store back end
// Holds the frame memory and page dirty bits, executes load, read, write
// and flush commands and hands result items to the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tfsdp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire tfsdp_pkg::cmd_t cmd,
  output logic                 cmd_take,
  input  wire logic            res_full,
  output logic                 res_push,
  output tfsdp_pkg::res_t      res
);
  import tfsdp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FL_RD = 2'd2;
  localparam logic [1:0] S_FL_WR = 2'd3;

  logic [WORD_W-1:0]    mem [NUM_TAGS];
  logic [WORD_W-1:0]    rdata;
  logic                 rd_en;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [WORD_W-1:0]    wr_data;

  logic [1:0]           state;
  logic [1:0]           state_next;
  cmd_t                 cur;
  logic [NUM_PAGES-1:0] dirty;
  logic [NUM_PAGES-1:0] dirty_next;
  logic [SLOT_W-1:0]    slot_cnt;
  logic [SLOT_W-1:0]    slot_cnt_next;

  logic [7:0]           tag_byte;
  logic [1:0]           chk;
  logic [VALUE_W-1:0]   stored_value;
  logic [PAGE_W-1:0]    cur_page;
  logic [PAGE_W-1:0]    fl_page;
  logic [FRAME_W-1:0]   fl_frame;
  logic                 fl_last;

  // Frame memory: one read port with registered data, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
    if (wr_en) mem[cur.slot] <= wr_data;
  end

  assign tag_byte     = rdata[7:0];
  assign stored_value = rdata[8 +: VALUE_W];
  assign cur_page     = page_of(cur.slot);
  assign fl_page      = page_of(slot_cnt);
  assign fl_frame     = frame_of(slot_cnt);

  always_comb begin
    if (tag_byte == TAG_BYTE_BLANK || tag_byte == TAG_BYTE_ERASED) begin
      chk = ST_EMPTY;
    end else if (tag_byte != {2'b00, cur.tag}) begin
      chk = ST_MISMATCH;
    end else begin
      chk = ST_OK;
    end
  end

  // The final flush word is the last slot overall, or the end of a page
  // with no dirty page above it.
  assign fl_last = (slot_cnt == SLOT_W'(NUM_TAGS - 1)) ||
                   ((fl_frame == FRAME_W'(FRAMES_PER_PAGE - 1)) &&
                    ((dirty >> (int'(fl_page) + 1)) == '0));

  always_comb begin
    state_next    = state;
    dirty_next    = dirty;
    slot_cnt_next = slot_cnt;
    cmd_take      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cmd.slot;
    wr_en         = 1'b0;
    wr_data       = {cur.pad, cur.value, cur.stb};
    res_push      = 1'b0;
    res           = '0;
    res.last      = 1'b1;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          if (cmd.opcode == OP_FLUSH && dirty != '0) begin
            slot_cnt_next = '0;
            state_next    = S_FL_RD;
          end else begin
            rd_en      = 1'b1;
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
          if (cur.opcode == OP_FLUSH) begin
            res.status = ST_NONE_DIRTY;
          end else if (cur.bad) begin
            res.status = ST_EMPTY;
          end else begin
            case (cur.opcode)
              OP_LOAD: begin
                wr_en = 1'b1;
              end
              OP_READ: begin
                res.status = chk;
                if (chk == ST_OK) res.read_value = stored_value;
              end
              OP_WRITE: begin
                if (chk == ST_OK && stored_value == cur.value) begin
                  res.unchanged = 1'b1;
                end else begin
                  wr_en      = 1'b1;
                  wr_data    = {rdata[WORD_W-1 -: 8], cur.value, 2'b00, cur.tag};
                  dirty_next = dirty | (NUM_PAGES'(1) << cur_page);
                end
              end
              default: begin
                res.status = ST_NONE_DIRTY;
              end
            endcase
          end
        end
      end

      S_FL_RD: begin
        if (dirty[fl_page]) begin
          rd_en      = 1'b1;
          rd_addr    = slot_cnt;
          state_next = S_FL_WR;
        end else begin
          slot_cnt_next = SLOT_W'((SLOT_W + 5)'(slot_cnt) + (SLOT_W + 5)'(FRAMES_PER_PAGE)
                                  - (SLOT_W + 5)'(fl_frame));
        end
      end

      S_FL_WR: begin
        if (!res_full) begin
          res_push        = 1'b1;
          res.kind        = KIND_FLUSH;
          res.page_index  = 2'(fl_page);
          res.frame_index = 3'(fl_frame);
          res.frame_word  = rdata;
          res.last        = fl_last;
          if (fl_last) begin
            dirty_next = '0;
            state_next = S_IDLE;
          end else begin
            slot_cnt_next = slot_cnt + SLOT_W'(1);
            state_next    = S_FL_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dirty <= '0;
    end else begin
      state <= state_next;
      dirty <= dirty_next;
    end
  end

  always_ff @(posedge clk) begin
    slot_cnt <= slot_cnt_next;
    if (cmd_take) cur <= cmd;
  end

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_write_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_EXEC))
    else $error("frame memory written outside command execution");

  a_flush_clears_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FL_WR && res_push && res.last) |=> (dirty == '0))
    else $error("dirty pages not cleared after final flush word");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (state == S_IDLE && cmd_valid))
    else $error("command taken while busy");
`endif

endmodule

`default_nettype wire

@@ src/tfsdp_outq.sv @@
// ---------------------------------------------------------------------------
// Tagged frame store result queue
// Two-entry queue of result items between the back end and the result ports.
// ---------------------------------------------------------------------------
`default_nettype none

module tfsdp_outq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            res_push,
  input  wire tfsdp_pkg::res_t res_in,
  output logic                 res_full,
  output logic                 empty,
  input  wire logic            pop,
  output tfsdp_pkg::res_t      res_out
);
  import tfsdp_pkg::*;

  res_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       pop_ok;

  assign res_full = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign res_out  = q[rp];
  assign pop_ok   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (res_push) wp <= ~wp;
      if (pop_ok) rp <= ~rp;
      cnt <= cnt + 2'(res_push) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) q[wp] <= res_in;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result queue count out of range");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst)
    !(res_full && empty))
    else $error("result queue full and empty at once");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (res_push && !pop_ok) |=> (cnt == $past(cnt) + 2'd1))
    else $error("result queue count did not grow on a push");
`endif

endmodule

`default_nettype wire

@@ src/tagged_frame_store_dirty_pages_top.sv @@
// Path: an item accepted into the front queue is taken by the back end, which
// reads its frame, writes back where needed and pushes its result into the
// result queue. The back end takes a new load, read or write only after it
// has pushed the result of the last, following the read then compare-and-write
// sequence on the frame memory. Flush: the item is taken, then every frame
// of each dirty page is read and emitted, clean pages skipped. Reset (rst,
// synchronous): empties both queues and clears all page dirty bits.
// ---------------------------------------------------------------------------
// Tagged frame store with dirty page tracking
// RAM shadow of tagged parameter frames, with load, checked read, skipping
// write and page flush operations.
// ---------------------------------------------------------------------------
`default_nettype none

module tagged_frame_store_dirty_pages_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode,
  input  wire logic [5:0]  tag,
  input  wire logic [7:0]  stored_tag_byte,
  input  wire logic [7:0]  pad_byte,
  input  wire logic [47:0] value,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind,
  output logic [1:0]       status,
  output logic             unchanged,
  output logic [47:0]      read_value,
  output logic [1:0]       page_index,
  output logic [2:0]       frame_index,
  output logic [63:0]      frame_word,
  output logic             last
);
  import tfsdp_pkg::*;

  // The front end decodes each incoming item into a command: the tag is
  // range checked and turned into a frame slot. Commands wait in a short
  // queue so the input side keeps taking items while the back end works.
  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // The back end owns the frame memory and the per-page dirty bits. Each
  // load, read or write reads the frame first, then decides and writes back
  // as needed when its result is pushed; a flush walks each dirty page's slots.
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;

  tfsdp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .opcode          (opcode),
    .tag             (tag),
    .stored_tag_byte (stored_tag_byte),
    .pad_byte        (pad_byte),
    .value           (value),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take)
  );

  tfsdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result items are registered in a small queue, so a result waiting to be
  // popped never holds up the back end until the queue fills.
  tfsdp_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  // The oldest waiting item is shown on the result ports while empty is low.
  assign kind        = res_out.kind;
  assign status      = res_out.status;
  assign unchanged   = res_out.unchanged;
  assign read_value  = res_out.read_value;
  assign page_index  = res_out.page_index;
  assign frame_index = res_out.frame_index;
  assign frame_word  = res_out.frame_word;
  assign last        = res_out.last;

endmodule

`default_nettype wire
